### rtl/core/frsr_pkg.sv
package frsr_pkg;

    localparam int MAX_SLOTS_DEF = 16;
    localparam logic [4:0] SLOTS_RESET = 5'd3;
    localparam logic [31:0] SERIAL_RESET = 32'd1;

    localparam logic [2:0] REQ_BEGIN    = 3'd0;
    localparam logic [2:0] REQ_SUBMIT   = 3'd1;
    localparam logic [2:0] REQ_COMPLETE = 3'd2;
    localparam logic [2:0] REQ_CANCEL   = 3'd3;
    localparam logic [2:0] REQ_QUERY    = 3'd4;
    localparam logic [2:0] REQ_RESET    = 3'd5;

    localparam logic [1:0] ST_AVAILABLE = 2'd0;
    localparam logic [1:0] ST_RECORDING = 2'd1;
    localparam logic [1:0] ST_SUBMITTED = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  slot_sel;
        logic [31:0] token_serial;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [3:0]  granted_slot;
        logic [31:0] granted_serial;
        logic [3:0]  ptr_after;
    } t_res;

    // classified request handed from the front queue to the back
    typedef struct packed {
        t_req req;
        logic in_range;
    } t_cmd;

endpackage

### rtl/core/frsr_ram.sv
module frsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/frsr_front.sv
module frsr_front #(
    parameter int MAX_SLOTS = frsr_pkg::MAX_SLOTS_DEF,
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  frsr_pkg::t_req     i_req,
    input  logic [CW-1:0]      i_count,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_cmd_valid,
    output frsr_pkg::t_cmd     o_cmd
);

    frsr_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           push_ok;
    logic           pop_ok;
    frsr_pkg::t_cmd cmd_in;

    assign push_ok = i_push && (r_cnt != 2'd2);
    assign pop_ok  = i_pop && (r_cnt != 2'd0);

    always_comb begin
        cmd_in.req      = i_req;
        cmd_in.in_range = ({1'b0, i_req.slot_sel} < 9'(i_count));
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

endmodule

### rtl/core/frsr_back.sv
module frsr_back #(
    parameter int MAX_SLOTS = frsr_pkg::MAX_SLOTS_DEF,
    localparam int CW = $clog2(MAX_SLOTS + 1),
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [CW-1:0]  i_count,
    input  logic           i_cmd_valid,
    input  frsr_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_res_valid,
    output frsr_pkg::t_res o_res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic           r_fsm;
    logic           n_fsm;
    frsr_pkg::t_cmd r_cmd;
    logic [1:0]     r_state [MAX_SLOTS];
    logic [1:0]     n_state [MAX_SLOTS];
    logic [IW-1:0]  r_ptr;
    logic [IW-1:0]  n_ptr;
    logic [31:0]    r_serial;
    logic [31:0]    n_serial;
    logic           r_res_valid;
    frsr_pkg::t_res r_res;
    frsr_pkg::t_res n_res;

    logic           ram_we;
    logic [31:0]    ram_rdata;
    logic [IW-1:0]  slot_a;
    logic [CW:0]    ptr_inc;
    logic [31:0]    serial_inc;
    logic           tok_match;

    assign o_pop  = (r_fsm == S_IDLE) && i_cmd_valid;
    assign slot_a = r_cmd.req.slot_sel[IW-1:0];

    assign ptr_inc    = (CW + 1)'(r_ptr) + (CW + 1)'(1);
    assign serial_inc = r_serial + 32'd1;
    assign tok_match  = (ram_rdata == r_cmd.req.token_serial);

    // slot serials: read at pop, written by a granted begin
    frsr_ram #(
        .WIDTH(32),
        .DEPTH(MAX_SLOTS)
    ) u_serial_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(r_ptr),
        .i_wr_data(r_serial),
        .i_rd_en  (o_pop),
        .i_rd_addr(i_cmd.req.slot_sel[IW-1:0]),
        .o_rd_data(ram_rdata)
    );

    always_comb begin
        n_fsm    = r_fsm;
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_serial = r_serial;
        ram_we   = 1'b0;
        n_res    = '0;
        n_res.ptr_after = 4'(r_ptr);
        case (r_fsm)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_fsm = S_EXEC;
                end
            end
            S_EXEC: begin
                n_fsm = S_IDLE;
                case (r_cmd.req.req_type)
                    frsr_pkg::REQ_BEGIN: begin
                        if ((CW'(r_ptr) < i_count)
                                && (r_state[r_ptr] == frsr_pkg::ST_AVAILABLE)) begin
                            n_res.ok             = 1'b1;
                            n_res.granted_slot   = 4'(r_ptr);
                            n_res.granted_serial = r_serial;
                            // skip zero on wrap
                            n_serial = (serial_inc == 32'd0) ? 32'd1 : serial_inc;
                            n_state[r_ptr] = frsr_pkg::ST_RECORDING;
                            ram_we = 1'b1;
                            n_ptr = (ptr_inc >= (CW + 1)'(i_count)) ? '0 : IW'(ptr_inc);
                        end
                    end
                    frsr_pkg::REQ_SUBMIT: begin
                        if (r_cmd.in_range && (r_state[slot_a] == frsr_pkg::ST_RECORDING)
                                && tok_match) begin
                            n_state[slot_a] = frsr_pkg::ST_SUBMITTED;
                            n_res.ok = 1'b1;
                        end
                    end
                    frsr_pkg::REQ_COMPLETE: begin
                        if (r_cmd.in_range && (r_state[slot_a] == frsr_pkg::ST_SUBMITTED)) begin
                            n_state[slot_a] = frsr_pkg::ST_AVAILABLE;
                            n_res.ok = 1'b1;
                        end
                    end
                    frsr_pkg::REQ_CANCEL: begin
                        if (r_cmd.in_range && (r_state[slot_a] == frsr_pkg::ST_RECORDING)
                                && tok_match) begin
                            n_state[slot_a] = frsr_pkg::ST_AVAILABLE;
                            n_ptr = slot_a;
                            n_res.ok = 1'b1;
                        end
                    end
                    frsr_pkg::REQ_QUERY: begin
                        n_res.ok = r_cmd.in_range
                                && (r_state[slot_a] == frsr_pkg::ST_SUBMITTED);
                    end
                    frsr_pkg::REQ_RESET: begin
                        // serials stay in the RAM; only a recording slot reads them
                        for (int i = 0; i < MAX_SLOTS; i++) begin
                            n_state[i] = frsr_pkg::ST_AVAILABLE;
                        end
                        n_ptr = '0;
                        n_res.ok = 1'b1;
                    end
                    default: begin
                    end
                endcase
                n_res.ptr_after = 4'(n_ptr);
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_ptr       <= '0;
            r_serial    <= frsr_pkg::SERIAL_RESET;
            r_res_valid <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_state[i] <= frsr_pkg::ST_AVAILABLE;
            end
        end else begin
            r_fsm       <= n_fsm;
            r_ptr       <= n_ptr;
            r_serial    <= n_serial;
            r_state     <= n_state;
            r_res_valid <= (r_fsm == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_fsm == S_EXEC) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### rtl/core/frame_slot_ring_scheduler_top.sv
// Channel   Direction  Handshake                 Beat
// command   in         start & !busy             i_req   (t_req)
// result    out        o_res_valid, one cycle    o_res   (t_res)
// config    in         i_cfg_valid & o_cfg_ready i_cfg_data (slots_in_use)
//
// The back pops a request while idle, reading the slot serial RAM (registered
// read), then executes it against the slot states; it pops nothing meanwhile.
// The result beat comes from a register that is loaded in the execute step.
// A 2-entry queue separates the front from the back; busy is high while it is full.
// Synchronous reset frees all slots, pointer 0, serial 1, slots_in_use 3; the
// serial RAM is not cleared, no sweep is needed. Results cannot be stalled.
module frame_slot_ring_scheduler_top #(
    parameter int MAX_SLOTS = frsr_pkg::MAX_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  frsr_pkg::t_req i_req,
    output logic           o_res_valid,
    output frsr_pkg::t_res o_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [4:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_SLOTS + 1);

    logic [4:0]     r_slots;
    logic [CW-1:0]  count;
    logic           cmd_valid;
    logic           pop;
    frsr_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= frsr_pkg::SLOTS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slots <= i_cfg_data;
        end
    end

    // clamp slot count to 1..MAX_SLOTS
    always_comb begin
        if (r_slots == 5'd0) begin
            count = CW'(1);
        end else if (32'(r_slots) > MAX_SLOTS) begin
            count = CW'(MAX_SLOTS);
        end else begin
            count = CW'(r_slots);
        end
    end

    frsr_front #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (start),
        .i_req      (i_req),
        .i_count    (count),
        .o_full     (busy),
        .i_pop      (pop),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd)
    );

    frsr_back #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_count    (count),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_pop      (pop),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

endmodule

### rtl/core/frsr_checker.sv
module frsr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           busy,
    input logic           o_res_valid,
    input frsr_pkg::t_res o_res
);

    // the back pops no request while executing one, so beats never come back to back
    a_res_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result beats on consecutive cycles");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_res_valid)
        else $error("busy or result right after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.ok |-> o_res.granted_slot == 4'd0
            && o_res.granted_serial == 32'd0)
        else $error("failed request carries a grant");

    a_serial_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.granted_serial != 32'd0 |-> o_res.ok)
        else $error("grant serial without success");

endmodule

bind frame_slot_ring_scheduler_top frsr_checker u_frsr_checker (.*);

### test/frame_slot_ring_scheduler_top_tb.sv
module frame_slot_ring_scheduler_top_tb;

    import frsr_pkg::*;

    localparam int RING_DEPTH = MAX_SLOTS_DEF;
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 182;

    typedef struct packed {
        logic [RING_DEPTH-1:0][1:0]  st;
        logic [RING_DEPTH-1:0][31:0] ser;
        logic [3:0]                  ptr;
        logic [31:0]                 ctr;
        logic [4:0]                  cnt;
    } t_ring_model;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_req       i_req = '0;
    logic       o_res_valid;
    t_res       o_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [4:0] i_cfg_data = '0;

    // live tracks accepted requests, plan runs ahead at generation time
    t_ring_model live_ring;
    t_ring_model plan_ring;

    t_req req_q[$];
    t_res grant_q[$];
    t_res fresh_res;

    int gap_pct = 24;
    int err_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int cfg_writes = 0;

    frame_slot_ring_scheduler_top #(
        .MAX_SLOTS(RING_DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_res_valid(o_res_valid),
        .o_res(o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int slot_lim(logic [4:0] cnt);
        if (cnt == 5'd0) return 1;
        if (int'(cnt) > RING_DEPTH) return RING_DEPTH;
        return int'(cnt);
    endfunction

    task automatic ring_clear(output t_ring_model s);
        s.st  = '0;
        s.ser = '0;
        s.ptr = '0;
        s.ctr = SERIAL_RESET;
        s.cnt = SLOTS_RESET;
    endtask

    task automatic ring_step(inout t_ring_model s, input t_req r, output t_res res);
        int n;
        int idx;
        bit hit;
        n = slot_lim(s.cnt);
        idx = int'(r.slot_sel);
        hit = idx < n;
        res = '0;
        case (r.req_type)
            REQ_BEGIN: begin
                if (int'(s.ptr) < n && s.st[s.ptr] == ST_AVAILABLE) begin
                    res.granted_slot = s.ptr;
                    res.granted_serial = s.ctr;
                    s.st[s.ptr] = ST_RECORDING;
                    s.ser[s.ptr] = s.ctr;
                    s.ctr = s.ctr + 32'd1;
                    // skip 0 on wrap
                    if (s.ctr == 32'd0) s.ctr = 32'd1;
                    s.ptr = (int'(s.ptr) + 1 >= n) ? 4'd0 : s.ptr + 4'd1;
                    res.ok = 1'b1;
                end
            end
            REQ_SUBMIT: begin
                if (hit && s.st[idx] == ST_RECORDING && s.ser[idx] == r.token_serial) begin
                    s.st[idx] = ST_SUBMITTED;
                    res.ok = 1'b1;
                end
            end
            REQ_COMPLETE: begin
                if (hit && s.st[idx] == ST_SUBMITTED) begin
                    s.st[idx] = ST_AVAILABLE;
                    res.ok = 1'b1;
                end
            end
            REQ_CANCEL: begin
                if (hit && s.st[idx] == ST_RECORDING && s.ser[idx] == r.token_serial) begin
                    s.st[idx] = ST_AVAILABLE;
                    s.ptr = idx[3:0];
                    res.ok = 1'b1;
                end
            end
            REQ_QUERY: begin
                res.ok = hit && s.st[idx] == ST_SUBMITTED;
            end
            REQ_RESET: begin
                s.st  = '0;
                s.ser = '0;
                s.ptr = '0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.ptr_after = s.ptr;
    endtask

    task automatic queue_req(input logic [2:0] kind, input logic [7:0] idx,
                             input logic [31:0] tok);
        t_req r;
        t_res unused;
        r.req_type = kind;
        r.slot_sel = idx;
        r.token_serial = tok;
        ring_step(plan_ring, r, unused);
        req_q.push_back(r);
    endtask

    function automatic int pick_slot(t_ring_model s, logic [1:0] want);
        int hits[$];
        int n;
        n = slot_lim(s.cnt);
        for (int i = 0; i < n; i++)
            if (s.st[i] == want) hits.push_back(i);
        if (hits.size() == 0) return -1;
        return hits[$urandom_range(hits.size() - 1)];
    endfunction

    // mostly well-formed frame lifecycles, the rest is noise
    task automatic queue_random_req();
        logic [2:0]  kind;
        logic [7:0]  idx;
        logic [31:0] tok;
        int roll;
        int n;
        int s;
        n = slot_lim(plan_ring.cnt);
        roll = $urandom_range(99);
        idx = 8'($urandom_range(255));
        tok = $urandom;
        if (roll < 30) begin
            kind = REQ_BEGIN;
        end else if (roll < 52 || (roll >= 66 && roll < 74)) begin
            kind = (roll < 52) ? REQ_SUBMIT : REQ_CANCEL;
            s = pick_slot(plan_ring, ST_RECORDING);
            if (s >= 0) begin
                idx = 8'(s);
                tok = plan_ring.ser[s];
            end else begin
                idx = 8'($urandom_range(n - 1));
            end
            if ($urandom_range(9) == 0) tok = tok ^ (32'd1 << $urandom_range(31));
        end else if (roll < 66) begin
            kind = REQ_COMPLETE;
            s = pick_slot(plan_ring, ST_SUBMITTED);
            idx = (s >= 0) ? 8'(s) : 8'($urandom_range(n - 1));
        end else if (roll < 86) begin
            kind = REQ_QUERY;
            if ($urandom_range(3) != 0) idx = 8'($urandom_range(n - 1));
        end else if (roll < 88) begin
            kind = REQ_RESET;
        end else if (roll < 91) begin
            kind = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        end else begin
            kind = 3'($urandom_range(7));
        end
        queue_req(kind, idx, tok);
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || start || grant_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_slot_count(input logic [4:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        live_ring.cnt = value;
        plan_ring.cnt = value;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // driver: present queued beats, hold a beat while busy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                ring_step(live_ring, i_req, fresh_res);
                grant_q.push_back(fresh_res);
                accepted_count++;
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (req_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                start <= 1'b1;
                i_req <= req_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            checked_count++;
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_res);
                err_count++;
            end else begin
                fresh_res = grant_q.pop_front();
                if (o_res.ok !== fresh_res.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $time,
                             fresh_res.ok, o_res.ok);
                    err_count++;
                end
                if (o_res.granted_slot !== fresh_res.granted_slot) begin
                    $display("%0t: granted_slot expected %0d actual %0d", $time,
                             fresh_res.granted_slot, o_res.granted_slot);
                    err_count++;
                end
                if (o_res.granted_serial !== fresh_res.granted_serial) begin
                    $display("%0t: granted_serial expected %h actual %h", $time,
                             fresh_res.granted_serial, o_res.granted_serial);
                    err_count++;
                end
                if (o_res.ptr_after !== fresh_res.ptr_after) begin
                    $display("%0t: next pointer expected %0d actual %0d", $time,
                             fresh_res.ptr_after, o_res.ptr_after);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #(12 * 200000);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [4:0] phase_slots [NUM_PHASES];
        phase_slots = '{5'd3, 5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd7, 5'd17, 5'd5, 5'd16};
        ring_clear(live_ring);
        ring_clear(plan_ring);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // lifecycle corners on the reset ring of three slots
        queue_req(REQ_QUERY, 8'd0, 32'd0);
        queue_req(REQ_BEGIN, 8'hFF, 32'hFFFF_FFFF);
        queue_req(REQ_BEGIN, 8'd0, 32'd0);
        queue_req(REQ_BEGIN, 8'hAA, 32'h5555_5555);
        queue_req(REQ_BEGIN, 8'd0, 32'd0);
        queue_req(REQ_SUBMIT, 8'd0, plan_ring.ser[0]);
        queue_req(REQ_SUBMIT, 8'd1, 32'hFFFF_FFFF);
        queue_req(REQ_SUBMIT, 8'd3, 32'd0);
        queue_req(REQ_QUERY, 8'd0, 32'd0);
        queue_req(REQ_QUERY, 8'hFF, 32'hFFFF_FFFF);
        queue_req(REQ_COMPLETE, 8'd0, 32'd0);
        queue_req(REQ_COMPLETE, 8'd0, 32'd0);
        queue_req(REQ_CANCEL, 8'd2, plan_ring.ser[2] ^ 32'h8000_0000);
        queue_req(REQ_CANCEL, 8'd2, plan_ring.ser[2]);
        queue_req(REQ_BEGIN, 8'd0, 32'd0);
        queue_req(REQ_SPARE_LO, 8'd1, 32'd1);
        queue_req(REQ_SPARE_HI, 8'hFF, 32'hFFFF_FFFF);
        queue_req(REQ_RESET, 8'hFF, 32'hFFFF_FFFF);
        queue_req(REQ_BEGIN, 8'd0, 32'd0);
        wait_drained();

        // shrink the ring under the pointer: begin fails until a cancel
        write_slot_count(5'd16);
        repeat (6) queue_req(REQ_BEGIN, 8'd0, 32'd0);
        wait_drained();
        write_slot_count(5'd4);
        queue_req(REQ_BEGIN, 8'd0, 32'd0);
        queue_req(REQ_CANCEL, 8'd2, plan_ring.ser[2]);
        queue_req(REQ_BEGIN, 8'd0, 32'd0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_slot_count(phase_slots[p]);
            gap_pct = (p == 2) ? 0 : 24;
            repeat (PHASE_ITEMS) queue_random_req();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("Ran %0d requests over %0d slot-count writes (0 to 31).",
                 accepted_count, cfg_writes);
        $display("Compared %0d result beats, %0d mismatches.", checked_count, err_count);
        if (err_count == 0 && grant_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/frsr_pkg.sv
rtl/core/frsr_ram.sv
rtl/core/frsr_front.sv
rtl/core/frsr_back.sv
rtl/core/frame_slot_ring_scheduler_top.sv
rtl/core/frsr_checker.sv
test/frame_slot_ring_scheduler_top_tb.sv
